@@ rtl/core/dcmb_pkg.sv @@
// ----------------------------------------------------------------------------
// dcmb_pkg
// Shared types, constants and helpers of the DCM balance controller: register
// indexes, sequencer states, datapath commands and the 32-bit saturation.
// ----------------------------------------------------------------------------
package dcmb_pkg;

	localparam int OPD_W  = 33;
	localparam int PROD_W = 50;
	localparam int ACC_W  = 52;
	localparam int FRAC_W = 16;

	typedef enum logic [2:0] {
		REG_KP     = 3'd0,
		REG_KI     = 3'd1,
		REG_KZMP   = 3'd2,
		REG_KCOM   = 3'd3,
		REG_LEAK   = 3'd4,
		REG_INV_W  = 3'd5,
		REG_ENABLE = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAK,
		ST_DIFF,
		ST_STEP,
		ST_INTEG,
		ST_VEL,
		ST_KP,
		ST_KI,
		ST_ZACC,
		ST_EZ,
		ST_KZ,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_LEAK,
		MUL_STEP,
		MUL_VEL,
		MUL_KP,
		MUL_KI,
		MUL_KZMP,
		MUL_KCOM
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_DES_SUB,
		ACC_ADD,
		ACC_CVD_ADD
	} acc_op_t;

	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     d_ld;
		logic     integ_ld;
		logic     zmp_ld;
		logic     ez_ld;
		logic     res_ld;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic run;
		logic out_full;
	} sts_t;

	typedef struct packed {
		logic [63:0] kp;
		logic [63:0] ki;
		logic [63:0] kzmp;
		logic [63:0] kcom;
		logic [30:0] leak;
		logic [30:0] inv_omega;
		logic        enable;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > ACC_W'(32'sh7FFFFFFF)) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -ACC_W'(33'sh080000000)) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/dcmb_regs.sv @@
// ----------------------------------------------------------------------------
// dcmb_regs
// Configuration register file. Writes to indexes outside the register list
// are dropped.
// ----------------------------------------------------------------------------
module dcmb_regs import dcmb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{kp: '0, ki: '0, kzmp: '0, kcom: '0, leak: '0,
				inv_omega: 31'd65536, enable: 1'b0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KP:     cfg_q.kp        <= cfg_data;
				REG_KI:     cfg_q.ki        <= cfg_data;
				REG_KZMP:   cfg_q.kzmp      <= cfg_data;
				REG_KCOM:   cfg_q.kcom      <= cfg_data;
				REG_LEAK:   cfg_q.leak      <= cfg_data[30:0];
				REG_INV_W:  cfg_q.inv_omega <= cfg_data[30:0];
				REG_ENABLE: cfg_q.enable    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/dcmb_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcmb_ctrl
// Sequencer that steps the shared multiplier and accumulator through the
// integrator update, the ZMP reference and the COM velocity reference.
// ----------------------------------------------------------------------------
module dcmb_ctrl import dcmb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (sts.skip) begin
						state_d = ST_FIN;
					end else if (sts.run) begin
						state_d = ST_LEAK;
					end else begin
						state_d = ST_VEL;
					end
				end
			end
			ST_LEAK: begin
				cmd.mul_sel = MUL_LEAK;
				state_d     = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.d_ld = 1'b1;
				state_d  = ST_STEP;
			end
			ST_STEP: begin
				cmd.mul_sel = MUL_STEP;
				state_d     = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.integ_ld = 1'b1;
				cmd.mul_sel  = MUL_VEL;
				state_d      = ST_KP;
			end
			ST_VEL: begin
				cmd.mul_sel = MUL_VEL;
				state_d     = ST_KP;
			end
			ST_KP: begin
				cmd.mul_sel = MUL_KP;
				cmd.acc_op  = ACC_DES_SUB;
				state_d     = ST_KI;
			end
			ST_KI: begin
				cmd.mul_sel = MUL_KI;
				cmd.acc_op  = ACC_ADD;
				state_d     = ST_ZACC;
			end
			ST_ZACC: begin
				cmd.zmp_ld = 1'b1;
				state_d    = ST_EZ;
			end
			ST_EZ: begin
				cmd.ez_ld   = 1'b1;
				cmd.mul_sel = MUL_KCOM;
				state_d     = ST_KZ;
			end
			ST_KZ: begin
				cmd.mul_sel = MUL_KZMP;
				cmd.acc_op  = ACC_CVD_ADD;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_full) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/dcmb_datapath.sv @@
// ----------------------------------------------------------------------------
// dcmb_datapath
// Operand capture, per-axis integrators, one shared 33x33 multiplier with a
// registered Q16.16 product, a wide accumulator and the result register.
// ----------------------------------------------------------------------------
module dcmb_datapath import dcmb_pkg::*; #(
	parameter int AXES = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               action,
	input  logic               axis,
	input  logic signed [31:0] com_meas,
	input  logic signed [31:0] zmp_meas,
	input  logic signed [31:0] dcm_meas,
	input  logic signed [31:0] com_des,
	input  logic signed [31:0] com_vel_des,
	input  logic signed [31:0] dcm_des,
	input  logic signed [31:0] dcm_vel_des,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               out_axis,
	output logic signed [31:0] com_vel_ref,
	output logic signed [31:0] zmp_ref
);

	localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

	logic signed [31:0] integ_mem_q [AXES];

	logic                     axis_ok;
	logic [IDX_W-1:0]         rd_idx;
	logic                     axis_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     zero_q;
	logic signed [31:0]       err_q;
	logic signed [31:0]       ec_q;
	logic signed [31:0]       dcm_des_q;
	logic signed [31:0]       cvd_q;
	logic signed [31:0]       dvd_q;
	logic signed [31:0]       zmp_meas_q;
	logic [15:0]              dt_q;
	logic signed [31:0]       integ_q;
	logic signed [31:0]       d_q;
	logic signed [31:0]       zmp_q;
	logic signed [31:0]       ez_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q;

	logic signed [OPD_W-1:0]   opa;
	logic signed [OPD_W-1:0]   opb;
	logic signed [2*OPD_W-1:0] full;
	logic signed [31:0]        gain_kp;
	logic signed [31:0]        gain_ki;
	logic signed [31:0]        gain_kzmp;
	logic signed [31:0]        gain_kcom;
	logic signed [31:0]        integ_new;

	assign axis_ok = (int'(axis) < AXES);
	assign rd_idx  = axis_ok ? IDX_W'(axis) : '0;

	assign sts.skip     = action || !axis_ok;
	assign sts.run      = cfg.enable;
	assign sts.out_full = out_valid_q && out_stall;

	assign gain_kp   = axis_q ? cfg.kp[63:32]   : cfg.kp[31:0];
	assign gain_ki   = axis_q ? cfg.ki[63:32]   : cfg.ki[31:0];
	assign gain_kzmp = axis_q ? cfg.kzmp[63:32] : cfg.kzmp[31:0];
	assign gain_kcom = axis_q ? cfg.kcom[63:32] : cfg.kcom[31:0];

	always_comb begin
		opa = '0;
		opb = '0;
		unique case (cmd.mul_sel)
			MUL_LEAK: begin
				opa = $signed({2'b00, cfg.leak});
				opb = OPD_W'(integ_q);
			end
			MUL_STEP: begin
				opa = $signed({17'd0, dt_q});
				opb = OPD_W'(d_q);
			end
			MUL_VEL: begin
				opa = OPD_W'(dvd_q);
				opb = $signed({2'b00, cfg.inv_omega});
			end
			MUL_KP: begin
				opa = OPD_W'(gain_kp);
				opb = OPD_W'(err_q);
			end
			MUL_KI: begin
				opa = OPD_W'(gain_ki);
				opb = OPD_W'(integ_q);
			end
			MUL_KZMP: begin
				opa = OPD_W'(gain_kzmp);
				opb = OPD_W'(ez_q);
			end
			MUL_KCOM: begin
				opa = OPD_W'(gain_kcom);
				opb = OPD_W'(ec_q);
			end
			default: begin
			end
		endcase
	end

	assign full      = opa * opb;
	assign integ_new = sat32(ACC_W'(integ_q) + ACC_W'(prod_q));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			axis_q     <= axis;
			idx_q      <= rd_idx;
			zero_q     <= sts.skip;
			err_q      <= sat32(ACC_W'(dcm_des) - ACC_W'(dcm_meas));
			ec_q       <= sat32(ACC_W'(com_des) - ACC_W'(com_meas));
			dcm_des_q  <= dcm_des;
			cvd_q      <= com_vel_des;
			dvd_q      <= dcm_vel_des;
			zmp_meas_q <= zmp_meas;
			dt_q       <= time_step;
			integ_q    <= integ_mem_q[rd_idx];
		end
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= $signed(full[2*OPD_W-1:FRAC_W]);
		end
		if (cmd.d_ld) begin
			d_q <= sat32(ACC_W'(err_q) - ACC_W'(prod_q));
		end
		if (cmd.integ_ld) begin
			integ_q <= integ_new;
		end
		unique case (cmd.acc_op)
			ACC_DES_SUB: acc_q <= ACC_W'(dcm_des_q) - ACC_W'(prod_q);
			ACC_ADD:     acc_q <= acc_q + ACC_W'(prod_q);
			ACC_CVD_ADD: acc_q <= ACC_W'(cvd_q) + ACC_W'(prod_q);
			default: begin
			end
		endcase
		if (cmd.zmp_ld) begin
			zmp_q <= sat32(acc_q + ACC_W'(prod_q));
		end
		if (cmd.ez_ld) begin
			ez_q <= sat32(ACC_W'(zmp_q) - ACC_W'(zmp_meas_q));
		end
		if (cmd.res_ld) begin
			out_axis    <= axis_q;
			zmp_ref     <= zero_q ? 32'sd0 : zmp_q;
			com_vel_ref <= zero_q ? 32'sd0 : sat32(acc_q - ACC_W'(prod_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				integ_mem_q[i] <= '0;
			end
		end else if (cmd.capture && action) begin
			for (int i = 0; i < AXES; i++) begin
				integ_mem_q[i] <= '0;
			end
		end else if (cmd.integ_ld) begin
			integ_mem_q[idx_q] <= integ_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/dcm_balance_pi_controller.sv @@
// ----------------------------------------------------------------------------
// dcm_balance_pi_controller
// DCM balance law with a leaky per-axis integrator, one axis per transaction.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An update steps through LEAK, DIFF,
// STEP and INTEG when the integrator runs and through VEL when it is frozen,
// then through KP, KI, ZACC, EZ, KZ and FIN, where the result register is
// loaded, because its Q16.16 products, the leak and step products only when
// the integrator runs, go one after another through a single 33x33 multiplier
// with a registered product. A reset action or an axis outside AXES goes
// straight to FIN and loads zeros. The sequencer takes the next transaction
// in the cycle after the load. The result register lets the next transaction
// be accepted while the previous result is still waiting downstream.
module dcm_balance_pi_controller import dcmb_pkg::*; #(
	parameter int AXES = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic               axis,
	input  logic signed [31:0] com_meas,
	input  logic signed [31:0] zmp_meas,
	input  logic signed [31:0] dcm_meas,
	input  logic signed [31:0] com_des,
	input  logic signed [31:0] com_vel_des,
	input  logic signed [31:0] dcm_des,
	input  logic signed [31:0] dcm_vel_des,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               out_axis,
	output logic signed [31:0] com_vel_ref,
	output logic signed [31:0] zmp_ref
);

	cfg_t cfg;
	cmd_t ctl_cmd;
	sts_t ctl_sts;

	dcmb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dcmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	dcmb_datapath #(
		.AXES (AXES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (ctl_cmd),
		.sts         (ctl_sts),
		.action      (action),
		.axis        (axis),
		.com_meas    (com_meas),
		.zmp_meas    (zmp_meas),
		.dcm_meas    (dcm_meas),
		.com_des     (com_des),
		.com_vel_des (com_vel_des),
		.dcm_des     (dcm_des),
		.dcm_vel_des (dcm_vel_des),
		.time_step   (time_step),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_axis    (out_axis),
		.com_vel_ref (com_vel_ref),
		.zmp_ref     (zmp_ref)
	);

	// An accepted transaction keeps the input side busy in the cycle after acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted again right after acceptance");

	// The result register is never overwritten while its content is held.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.res_ld |-> !(out_valid && out_stall))
		else $error("result register loaded while a stalled result is pending");

	// A new result only appears after the sequencer loaded it.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl_cmd.res_ld))
		else $error("result valid raised without a load");

	// The integrator is only written while no new transaction is taken.
	a_integ_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.integ_ld |-> in_stall)
		else $error("integrator update while accepting input");

endmodule
